[rtl/core/gsts_pkg.sv]
`default_nettype none
package gsts_pkg;
	localparam int MAX_JOBS = 64;
	localparam int MAX_MACHINES = 8;
	localparam int TIME_BITS = 16;
	localparam int ROWS = MAX_JOBS + 1;
	localparam int MAT_DEPTH = ROWS * ROWS;
	localparam int MAT_AW = $clog2(MAT_DEPTH);
	localparam int JW = 7;
	localparam int MW = 3;
	localparam int MIW = $clog2(MAX_MACHINES) > 0 ? $clog2(MAX_MACHINES) : 1;
	localparam int RJW = $clog2(ROWS);
	localparam logic [31:0] COST_LIMIT = 32'd99999999;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_PLACE = 2'd1;
	localparam logic [1:0] CMD_STEP = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0] status;
		logic [MW-1:0] chosen_machine;
		logic [JW-1:0] chosen_job;
		logic [31:0] machine_total;
		logic [31:0] schedule_total;
	} result_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage
`default_nettype wire

[rtl/core/gsts_ram.sv]
`default_nettype none
module gsts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4225,
	parameter int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/gsts_ctrl.sv]
`default_nettype none
module gsts_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_go,
	input wire logic [1:0] cmd,
	input wire logic [6:0] from_job,
	input wire logic [6:0] to_job,
	input wire logic [15:0] setup_time,
	input wire logic [2:0] machine_index,
	input wire logic [6:0] initial_job,
	input wire logic [3:0] num_machines,
	input wire logic [6:0] num_jobs,
	output logic busy,
	output logic res_valid,
	output gsts_pkg::result_t res,
	output logic mat_we,
	output logic [gsts_pkg::MAT_AW-1:0] mat_waddr,
	output logic [gsts_pkg::TIME_BITS-1:0] mat_wdata,
	output logic [gsts_pkg::MAT_AW-1:0] mat_raddr,
	input wire logic [gsts_pkg::TIME_BITS-1:0] mat_rdata
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PLACE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_TOTAL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam int JCW = gsts_pkg::RJW + 1;
	localparam int MIW_L = gsts_pkg::MIW;

	logic [2:0] state_q;
	logic [gsts_pkg::MAX_MACHINES-1:0][gsts_pkg::JW-1:0] last_q;
	logic [gsts_pkg::MAX_MACHINES-1:0][6:0] cnt_q;
	logic [gsts_pkg::MAX_MACHINES-1:0][31:0] ssum_q;
	logic [gsts_pkg::MAX_MACHINES-1:0][31:0] tct_q;
	logic [gsts_pkg::ROWS-1:0] done_q;

	logic [MIW_L-1:0] m_q, bm_q;
	logic [JCW-1:0] j_q, bj_q;
	logic issue_q, rd_s1;
	logic [MIW_L-1:0] m_s1;
	logic [JCW-1:0] j_s1;
	logic [31:0] best_q;
	logic [gsts_pkg::TIME_BITS-1:0] bs_q;
	logic [31:0] tot_q;
	logic [MIW_L:0] tm_q;
	logic [MIW_L-1:0] pm_q;
	logic [gsts_pkg::JW-1:0] pj_q;
	logic [1:0] st_q;
	logic [MIW_L:0] nm;
	logic [JCW-1:0] nj;
	logic [31:0] cost;
	logic scan_end;
	logic [gsts_pkg::MAT_AW-1:0] rd_addr;

	assign nm = ({1'b0, num_machines} > 5'(gsts_pkg::MAX_MACHINES)) ?
		(MIW_L+1)'(gsts_pkg::MAX_MACHINES) : (MIW_L+1)'(num_machines);
	assign nj = ({1'b0, num_jobs} > 8'(gsts_pkg::MAX_JOBS)) ?
		JCW'(gsts_pkg::MAX_JOBS) : JCW'(num_jobs);

	always_comb begin
		rd_addr = gsts_pkg::MAT_AW'(32'(last_q[m_q]) * gsts_pkg::ROWS + 32'(j_q));
		if (state_q == S_IDLE) begin
			rd_addr = gsts_pkg::MAT_AW'(32'(initial_job));
		end
	end
	assign mat_raddr = rd_addr;
	assign mat_we = in_go && cmd == gsts_pkg::CMD_LOAD && from_job <= 7'(gsts_pkg::MAX_JOBS)
		&& to_job <= 7'(gsts_pkg::MAX_JOBS);
	assign mat_waddr = gsts_pkg::MAT_AW'(32'(from_job) * gsts_pkg::ROWS + 32'(to_job));
	assign mat_wdata = gsts_pkg::TIME_BITS'(setup_time);

	assign cost = gsts_pkg::sat_add(tct_q[m_s1],
		gsts_pkg::sat_add(ssum_q[m_s1], 32'(mat_rdata)));
	assign scan_end = (m_q == MIW_L'(nm - 1'b1)) && (j_q == nj);
	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= '0;
			cnt_q <= '0;
			ssum_q <= '0;
			tct_q <= '0;
			done_q <= '0;
			res_valid <= 1'b0;
			issue_q <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			rd_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_go) begin
						st_q <= gsts_pkg::ST_OK;
						pm_q <= '0;
						pj_q <= '0;
						best_q <= '0;
						tot_q <= '0;
						tm_q <= '0;
						state_q <= S_TOTAL;
						case (cmd)
							gsts_pkg::CMD_LOAD: begin
								if (!mat_we) st_q <= gsts_pkg::ST_RANGE;
							end
							gsts_pkg::CMD_PLACE: begin
								if ({1'b0, machine_index} >= 4'(nm) || initial_job == '0
									|| JCW'(initial_job) > nj) begin
									st_q <= gsts_pkg::ST_RANGE;
								end else begin
									pm_q <= MIW_L'(machine_index);
									pj_q <= initial_job;
									state_q <= S_PLACE;
								end
							end
							gsts_pkg::CMD_STEP: begin
								// no machine or no job in use: nothing to choose
								if (nm == '0 || nj == '0) begin
									st_q <= gsts_pkg::ST_NONE;
								end else begin
									m_q <= '0;
									j_q <= JCW'(1);
									bj_q <= '0;
									bm_q <= '0;
									best_q <= gsts_pkg::COST_LIMIT;
									issue_q <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							default: st_q <= gsts_pkg::ST_RANGE;
						endcase
					end
				end
				S_PLACE: begin
					last_q[pm_q] <= pj_q;
					cnt_q[pm_q] <= 7'd1;
					ssum_q[pm_q] <= 32'(mat_rdata);
					tct_q[pm_q] <= 32'(mat_rdata);
					best_q <= 32'(mat_rdata);
					done_q[pj_q[gsts_pkg::RJW-1:0]] <= 1'b1;
					state_q <= S_TOTAL;
				end
				S_SCAN: begin
					if (issue_q) begin
						rd_s1 <= !done_q[j_q[gsts_pkg::RJW-1:0]];
						m_s1 <= m_q;
						j_s1 <= j_q;
						if (scan_end) begin
							issue_q <= 1'b0;
						end else if (j_q == nj) begin
							j_q <= JCW'(1);
							m_q <= m_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					if (rd_s1 && cost < best_q) begin
						best_q <= cost;
						bm_q <= m_s1;
						bj_q <= j_s1;
						bs_q <= mat_rdata;
					end
					if (!issue_q && !rd_s1) begin
						if (bj_q == '0) begin
							st_q <= gsts_pkg::ST_NONE;
							best_q <= '0;
						end else begin
							pm_q <= bm_q;
							pj_q <= gsts_pkg::JW'(bj_q);
							last_q[bm_q] <= gsts_pkg::JW'(bj_q);
							if (cnt_q[bm_q] != 7'd127) cnt_q[bm_q] <= cnt_q[bm_q] + 1'b1;
							ssum_q[bm_q] <= gsts_pkg::sat_add(ssum_q[bm_q], 32'(bs_q));
							tct_q[bm_q] <= best_q;
							done_q[bj_q[gsts_pkg::RJW-1:0]] <= 1'b1;
						end
						state_q <= S_TOTAL;
					end
				end
				S_TOTAL: begin
					if (tm_q == nm) begin
						state_q <= S_DONE;
					end else begin
						tot_q <= gsts_pkg::sat_add(tot_q, tct_q[tm_q[MIW_L-1:0]]);
						tm_q <= tm_q + 1'b1;
					end
				end
				S_DONE: begin
					res_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		res.status = st_q;
		res.chosen_machine = gsts_pkg::MW'(pm_q);
		res.chosen_job = pj_q;
		res.machine_total = best_q;
		res.schedule_total = tot_q;
	end
endmodule
`default_nettype wire

[rtl/core/greedy_setup_time_scheduler.sv]
// load and rejected items pass from IDLE through TOTAL and DONE; a place item also passes PLACE
// a greedy step scans every machine and job pair in SCAN, one matrix read a cycle, then TOTAL and DONE
// throughput: one item at a time; the next item is taken the cycle after the result leaves
// the controller, and a result held behind a waiting output blocks it
// reset: arst_n clears control, machine state and the done map; the matrix is undefined until written
`default_nettype none
module greedy_setup_time_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] cmd,
	input wire logic [6:0] from_job,
	input wire logic [6:0] to_job,
	input wire logic [15:0] setup_time,
	input wire logic [2:0] machine_index,
	input wire logic [6:0] initial_job,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [2:0] chosen_machine,
	output logic [6:0] chosen_job,
	output logic [31:0] machine_total,
	output logic [31:0] schedule_total,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [2:0] A_MACH = 3'd0;
	localparam logic [2:0] A_JOBS = 3'd4;

	logic [3:0] nm_q;
	logic [6:0] nj_q;
	logic busy, res_valid, in_go, pend_q;
	gsts_pkg::result_t res;
	logic mat_we;
	logic [gsts_pkg::MAT_AW-1:0] mat_waddr, mat_raddr;
	logic [gsts_pkg::TIME_BITS-1:0] mat_wdata, mat_rdata;

	assign pready = 1'b1;
	assign in_ready = !busy && !pend_q && !res_valid;
	assign in_go = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm_q <= 4'd1;
			nj_q <= 7'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				A_MACH: nm_q <= pwdata[3:0];
				A_JOBS: nj_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			A_MACH: prdata = {28'd0, nm_q};
			A_JOBS: prdata = {25'd0, nj_q};
			default: prdata = '0;
		endcase
	end

	gsts_ram #(.WIDTH(gsts_pkg::TIME_BITS), .DEPTH(gsts_pkg::MAT_DEPTH)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
		.raddr(mat_raddr), .rdata(mat_rdata)
	);

	gsts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .cmd(cmd), .from_job(from_job),
		.to_job(to_job), .setup_time(setup_time), .machine_index(machine_index),
		.initial_job(initial_job), .num_machines(nm_q), .num_jobs(nj_q), .busy(busy),
		.res_valid(res_valid), .res(res), .mat_we(mat_we), .mat_waddr(mat_waddr),
		.mat_wdata(mat_wdata), .mat_raddr(mat_raddr), .mat_rdata(mat_rdata)
	);

	// pend_q: a finished result that cannot yet enter the output register
	gsts_pkg::result_t pend_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (pend_q && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
				pend_q <= 1'b0;
			end else if (res_valid) begin
				if (!out_valid || out_ready) out_valid <= 1'b1;
				else pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) pend_d_q <= res;
		if ((pend_q || res_valid) && (!out_valid || out_ready)) begin
			{status, chosen_machine, chosen_job, machine_total, schedule_total}
				<= pend_q ? pend_d_q : res;
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("item taken while busy");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !pend_q) else $error("result overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

[tb/sv/greedy_setup_time_scheduler_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module greedy_setup_time_scheduler_test;
	localparam logic [1:0] CMD_UNDEF = 2'd3;
	localparam logic [2:0] REG_NUM_MACHINES = 3'd0;
	localparam logic [2:0] REG_NUM_JOBS = 3'd4;

	class schedule_scoreboard;
		int unsigned num_machines_reg = 1;
		int unsigned num_jobs_reg = 1;
		logic [15:0] setup_times[gsts_pkg::ROWS*gsts_pkg::ROWS];
		bit loaded[gsts_pkg::ROWS*gsts_pkg::ROWS];
		bit done_map[gsts_pkg::ROWS];
		logic [6:0] last_job[gsts_pkg::MAX_MACHINES];
		logic [6:0] job_count[gsts_pkg::MAX_MACHINES];
		logic [31:0] setup_sum[gsts_pkg::MAX_MACHINES];
		logic [31:0] machine_tct[gsts_pkg::MAX_MACHINES];
		gsts_pkg::result_t expected_results[$];
		int errors = 0;
		int checked = 0;
		int by_status[4];

		function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function automatic int unsigned machines_used();
			return num_machines_reg > gsts_pkg::MAX_MACHINES ? gsts_pkg::MAX_MACHINES
				: num_machines_reg;
		endfunction

		function automatic int unsigned jobs_used();
			return num_jobs_reg > gsts_pkg::MAX_JOBS ? gsts_pkg::MAX_JOBS : num_jobs_reg;
		endfunction

		function automatic bit place_ok(logic [2:0] mi, logic [6:0] ij);
			return mi < machines_used() && ij != 0 && ij <= jobs_used();
		endfunction

		// matrix entries that an item would read and that were never loaded
		function automatic void unloaded_reads(logic [1:0] cmd, logic [2:0] mi,
				logic [6:0] ij, ref int idx[$]);
			idx.delete();
			if (cmd == gsts_pkg::CMD_PLACE && place_ok(mi, ij) && !loaded[ij])
				idx = {idx, int'(ij)};
			if (cmd == gsts_pkg::CMD_STEP)
				for (int m = 0; m < machines_used(); m++)
					for (int j = 1; j <= jobs_used(); j++)
						if (!done_map[j] && !loaded[int'(last_job[m])*gsts_pkg::ROWS+j])
							idx = {idx, int'(last_job[m])*gsts_pkg::ROWS + j};
		endfunction

		function automatic void put_job(int m, logic [6:0] j, logic [31:0] s,
				logic [31:0] cost);
			last_job[m] = j;
			if (job_count[m] < 127) job_count[m]++;
			setup_sum[m] = add_sat(setup_sum[m], s);
			machine_tct[m] = cost;
			done_map[j] = 1;
		endfunction

		function automatic void note_item(logic [1:0] cmd, logic [6:0] from, logic [6:0] to,
				logic [15:0] st, logic [2:0] mi, logic [6:0] ij);
			gsts_pkg::result_t r;
			logic [31:0] best, c, s, bs;
			int bm, bj;
			r = '0;
			case (cmd)
				gsts_pkg::CMD_LOAD: begin
					if (from > gsts_pkg::MAX_JOBS || to > gsts_pkg::MAX_JOBS)
						r.status = gsts_pkg::ST_RANGE;
					else begin
						setup_times[from*gsts_pkg::ROWS+to] = st;
						loaded[from*gsts_pkg::ROWS+to] = 1;
					end
				end
				gsts_pkg::CMD_PLACE: begin
					if (!place_ok(mi, ij)) r.status = gsts_pkg::ST_RANGE;
					else begin
						s = 32'(setup_times[ij]);
						last_job[mi] = 0;
						job_count[mi] = 0;
						setup_sum[mi] = 0;
						machine_tct[mi] = 0;
						put_job(int'(mi), ij, s, s);
						r.chosen_machine = mi;
						r.chosen_job = ij;
						r.machine_total = s;
					end
				end
				gsts_pkg::CMD_STEP: begin
					best = gsts_pkg::COST_LIMIT;
					bm = 0;
					bj = 0;
					bs = 0;
					for (int m = 0; m < machines_used(); m++)
						for (int j = 1; j <= jobs_used(); j++) begin
							if (done_map[j]) continue;
							s = 32'(setup_times[int'(last_job[m])*gsts_pkg::ROWS+j]);
							c = add_sat(machine_tct[m], add_sat(setup_sum[m], s));
							if (c < best) begin
								best = c;
								bm = m;
								bj = j;
								bs = s;
							end
						end
					if (bj == 0) r.status = gsts_pkg::ST_NONE;
					else begin
						put_job(bm, 7'(bj), bs, best);
						r.chosen_machine = 3'(bm);
						r.chosen_job = 7'(bj);
						r.machine_total = best;
					end
				end
				default: r.status = gsts_pkg::ST_RANGE;
			endcase
			r.schedule_total = 0;
			for (int m = 0; m < machines_used(); m++)
				r.schedule_total = add_sat(r.schedule_total, machine_tct[m]);
			expected_results = {expected_results, r};
		endfunction

		function automatic void check_result(gsts_pkg::result_t got);
			gsts_pkg::result_t e;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			checked++;
			by_status[e.status]++;
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status);
				errors++;
			end
			if (got.chosen_machine !== e.chosen_machine) begin
				$error("chosen_machine exp %0d got %0d", e.chosen_machine, got.chosen_machine);
				errors++;
			end
			if (got.chosen_job !== e.chosen_job) begin
				$error("chosen_job exp %0d got %0d", e.chosen_job, got.chosen_job);
				errors++;
			end
			if (got.machine_total !== e.machine_total) begin
				$error("machine_total exp %0d got %0d", e.machine_total, got.machine_total);
				errors++;
			end
			if (got.schedule_total !== e.schedule_total) begin
				$error("schedule_total exp %0d got %0d", e.schedule_total, got.schedule_total);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [6:0] from_job = '0;
	logic [6:0] to_job = '0;
	logic [15:0] setup_time = '0;
	logic [2:0] machine_index = '0;
	logic [6:0] initial_job = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [2:0] chosen_machine;
	logic [6:0] chosen_job;
	logic [31:0] machine_total;
	logic [31:0] schedule_total;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	schedule_scoreboard board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	bit big_fill = 0;
	int items_sent = 0;

	greedy_setup_time_scheduler u_top (.*);

	always #1 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 0;
			hold_cycles <= hold_cycles - 1;
		end else
			out_ready <= $urandom_range(99) >= recv_stall_pct;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({status, chosen_machine, chosen_job, machine_total,
				schedule_total});
	end

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == REG_NUM_MACHINES) board.num_machines_reg = data[3:0];
		else board.num_jobs_reg = data[6:0];
	endtask

	task automatic drive_item(input logic [1:0] c, input logic [6:0] f, input logic [6:0] t,
			input logic [15:0] st, input logic [2:0] mi, input logic [6:0] ij);
		int n;
		n = 0;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) n++;
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
		cmd <= c;
		from_job <= f;
		to_job <= t;
		setup_time <= st;
		machine_index <= mi;
		initial_job <= ij;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		board.note_item(c, f, t, st, mi, ij);
		items_sent++;
	endtask

	function automatic logic [15:0] fill_value();
		if (big_fill || $urandom_range(19) == 0) return 16'hFFFF;
		return 16'($urandom_range(0, 3000));
	endfunction

	// loads any unloaded matrix entry the item would read, then sends it
	task automatic send_item(input logic [1:0] c, input logic [6:0] f, input logic [6:0] t,
			input logic [15:0] st, input logic [2:0] mi, input logic [6:0] ij);
		int idx[$];
		board.unloaded_reads(c, mi, ij, idx);
		foreach (idx[k])
			drive_item(gsts_pkg::CMD_LOAD, 7'(idx[k] / gsts_pkg::ROWS),
				7'(idx[k] % gsts_pkg::ROWS), fill_value(), 3'($urandom_range(7)),
				7'($urandom_range(127)));
		drive_item(c, f, t, st, mi, ij);
	endtask

	task automatic random_item();
		int r;
		logic [6:0] f, t, ij;
		logic [2:0] mi;
		r = $urandom_range(99);
		f = 7'($urandom_range(0, board.jobs_used()));
		t = 7'($urandom_range(1, board.jobs_used()));
		mi = 3'($urandom_range(0, board.machines_used() - 1));
		ij = 7'($urandom_range(1, board.jobs_used()));
		if ($urandom_range(9) == 0) begin
			f = 7'($urandom_range(127));
			t = 7'($urandom_range(127));
			mi = 3'($urandom_range(7));
			ij = 7'($urandom_range(127));
		end
		if (r < 30) send_item(gsts_pkg::CMD_LOAD, f, t, fill_value(), 3'($urandom_range(7)),
			7'($urandom_range(127)));
		else if (r < 55) send_item(gsts_pkg::CMD_PLACE, 7'($urandom_range(127)),
			7'($urandom_range(127)), 16'($urandom_range(16'hFFFF)), mi, ij);
		else if (r < 95) send_item(gsts_pkg::CMD_STEP, 7'($urandom_range(127)),
			7'($urandom_range(127)), 16'($urandom_range(16'hFFFF)), 3'($urandom_range(7)),
			7'($urandom_range(127)));
		else send_item(CMD_UNDEF, 7'($urandom_range(127)), 7'($urandom_range(127)),
			16'($urandom_range(16'hFFFF)), 3'($urandom_range(7)), 7'($urandom_range(127)));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	int phase_machines[6] = '{2, 8, 3, 15, 5, 1};
	int phase_jobs[6] = '{4, 8, 16, 24, 40, 127};

	initial begin
		board = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (3) @(negedge clk);

		// directed: range checks, extremes, every command
		send_item(gsts_pkg::CMD_LOAD, 7'd0, 7'd1, 16'hFFFF, 3'd7, 7'd127);
		send_item(gsts_pkg::CMD_LOAD, 7'd65, 7'd0, 16'h0000, 3'd0, 7'd0);
		send_item(gsts_pkg::CMD_LOAD, 7'd0, 7'd127, 16'hFFFF, 3'd7, 7'd127);
		send_item(gsts_pkg::CMD_LOAD, 7'd64, 7'd64, 16'h0000, 3'd0, 7'd0);
		send_item(gsts_pkg::CMD_LOAD, 7'd127, 7'd127, 16'h1234, 3'd0, 7'd0);
		send_item(CMD_UNDEF, 7'd127, 7'd127, 16'hFFFF, 3'd7, 7'd127);
		send_item(gsts_pkg::CMD_STEP, 7'd0, 7'd0, 16'h0, 3'd0, 7'd0);
		send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd0, 7'd0);
		send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd0, 7'd2);
		send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd1, 7'd1);
		send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd7, 7'd127);
		send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd0, 7'd1);
		send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd0, 7'd1);
		send_item(gsts_pkg::CMD_STEP, 7'd0, 7'd0, 16'h0, 3'd0, 7'd0);
		drain();

		for (int p = 0; p < 6; p++) begin
			cfg_write(REG_NUM_MACHINES, 32'(phase_machines[p]));
			cfg_write(REG_NUM_JOBS, 32'(phase_jobs[p]));
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			if (p == 1) hold_cycles = 400;
			big_fill = (p == 5);
			if (p == 5) begin
				// one machine, long setups: totals grow towards the cost limit
				send_item(gsts_pkg::CMD_PLACE, 7'd0, 7'd0, 16'h0, 3'd0, 7'd64);
				repeat (64) send_item(gsts_pkg::CMD_STEP, 7'd0, 7'd0, 16'h0, 3'd0, 7'd0);
			end
			repeat (90) random_item();
			drain();
		end

		$display("%0d items sent, %0d results checked: %0d ok, %0d none left, %0d out of range",
			items_sent, board.checked, board.by_status[gsts_pkg::ST_OK],
			board.by_status[gsts_pkg::ST_NONE], board.by_status[gsts_pkg::ST_RANGE]);
		if (board.errors == 0 && board.expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
